[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while rst is high.
`define MKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define MKD_NEVER(label, expr, msg) \
  `MKD_ASSERT(label, !(expr), msg)

`endif

[hw/rtl/mkd_pkg.sv]
`default_nettype none

package mkd_pkg;

  localparam int MAX_RUN     = 3;
  localparam int RUN_W       = 2;
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = 3;
  localparam int CNT_W       = 4;
  localparam int TH_W        = 16;
  localparam int MAX_PATTERN = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_ECHO   = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_DASH    = 7'h2D;
  localparam logic [6:0] CH_DOT     = 7'h2E;
  localparam logic [6:0] CH_SLASH   = 7'h2F;
  localparam logic [6:0] CH_BAR     = 7'h7C;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_NINE    = 7'h39;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_LOWER_Z = 7'h7A;
  localparam logic [6:0] CASE_DIFF  = 7'h20;
  localparam logic [6:0] CH_NONE    = 7'h00;

  typedef struct packed {
    logic [1:0]  operating_mode;
    logic [11:0] dot_ticks;
    logic [3:0]  dash_multiple;
    logic [3:0]  letter_gap_multiple;
    logic [3:0]  word_gap_multiple;
    logic        caps_on;
    logic        russian_layout;
  } cfg_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       with_shift;
    logic       last_of_run;
  } res_t;

  function automatic res_t mk_res(input logic [6:0] ch, input logic sh);
    res_t r;
    r.char_code   = ch;
    r.with_shift  = sh;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Key is {length, elements right aligned}, dash = 1.
  function automatic logic [6:0] digit_lookup(input logic [7:0] key);
    logic [6:0] ch;
    unique case (key)
      {3'd5, 5'b11111}: ch = 7'("0");
      {3'd5, 5'b01111}: ch = 7'("1");
      {3'd5, 5'b00111}: ch = 7'("2");
      {3'd5, 5'b00011}: ch = 7'("3");
      {3'd5, 5'b00001}: ch = 7'("4");
      {3'd5, 5'b00000}: ch = 7'("5");
      {3'd5, 5'b10000}: ch = 7'("6");
      {3'd5, 5'b11000}: ch = 7'("7");
      {3'd5, 5'b11100}: ch = 7'("8");
      {3'd5, 5'b11110}: ch = 7'("9");
      default:          ch = CH_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] latin_lookup(input logic [7:0] key);
    logic [6:0] ch;
    unique case (key)
      {3'd2, 5'b00001}: ch = 7'("a");
      {3'd4, 5'b01000}: ch = 7'("b");
      {3'd4, 5'b01010}: ch = 7'("c");
      {3'd3, 5'b00100}: ch = 7'("d");
      {3'd1, 5'b00000}: ch = 7'("e");
      {3'd4, 5'b00010}: ch = 7'("f");
      {3'd3, 5'b00110}: ch = 7'("g");
      {3'd4, 5'b00000}: ch = 7'("h");
      {3'd2, 5'b00000}: ch = 7'("i");
      {3'd4, 5'b00111}: ch = 7'("j");
      {3'd3, 5'b00101}: ch = 7'("k");
      {3'd4, 5'b00100}: ch = 7'("l");
      {3'd2, 5'b00011}: ch = 7'("m");
      {3'd2, 5'b00010}: ch = 7'("n");
      {3'd3, 5'b00111}: ch = 7'("o");
      {3'd4, 5'b00110}: ch = 7'("p");
      {3'd4, 5'b01101}: ch = 7'("q");
      {3'd3, 5'b00010}: ch = 7'("r");
      {3'd3, 5'b00000}: ch = 7'("s");
      {3'd1, 5'b00001}: ch = 7'("t");
      {3'd3, 5'b00001}: ch = 7'("u");
      {3'd4, 5'b00001}: ch = 7'("v");
      {3'd3, 5'b00011}: ch = 7'("w");
      {3'd4, 5'b01001}: ch = 7'("x");
      {3'd4, 5'b01011}: ch = 7'("y");
      {3'd4, 5'b01100}: ch = 7'("z");
      default:          ch = digit_lookup(key);
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] russian_lookup(input logic [7:0] key);
    logic [6:0] ch;
    unique case (key)
      {3'd2, 5'b00001}: ch = 7'("f");
      {3'd4, 5'b01000}: ch = 7'(",");
      {3'd3, 5'b00011}: ch = 7'("d");
      {3'd3, 5'b00110}: ch = 7'("u");
      {3'd3, 5'b00100}: ch = 7'("l");
      {3'd1, 5'b00000}: ch = 7'("t");
      {3'd4, 5'b00001}: ch = 7'(";");
      {3'd4, 5'b01100}: ch = 7'("p");
      {3'd2, 5'b00000}: ch = 7'("b");
      {3'd4, 5'b00111}: ch = 7'("q");
      {3'd3, 5'b00101}: ch = 7'("r");
      {3'd4, 5'b00100}: ch = 7'("k");
      {3'd2, 5'b00011}: ch = 7'("v");
      {3'd2, 5'b00010}: ch = 7'("y");
      {3'd3, 5'b00111}: ch = 7'("j");
      {3'd4, 5'b00110}: ch = 7'("g");
      {3'd3, 5'b00010}: ch = 7'("h");
      {3'd3, 5'b00000}: ch = 7'("c");
      {3'd1, 5'b00001}: ch = 7'("n");
      {3'd3, 5'b00001}: ch = 7'("e");
      {3'd4, 5'b00010}: ch = 7'("a");
      {3'd4, 5'b00000}: ch = 7'("[");
      {3'd4, 5'b01010}: ch = 7'("w");
      {3'd4, 5'b01110}: ch = 7'("x");
      {3'd4, 5'b01111}: ch = 7'("i");
      {3'd4, 5'b01101}: ch = 7'("o");
      {3'd5, 5'b11011}: ch = 7'("]");
      {3'd4, 5'b01011}: ch = 7'("s");
      {3'd4, 5'b01001}: ch = 7'("m");
      {3'd5, 5'b00100}: ch = 7'("'");
      {3'd4, 5'b00011}: ch = 7'(".");
      {3'd4, 5'b00101}: ch = 7'("z");
      default:          ch = digit_lookup(key);
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mkd_if.sv]
`default_nettype none

interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_down;
  modport source (output valid, output key_down, input ready);
  modport sink (input valid, input key_down, output ready);
endinterface

interface mkd_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       with_shift;
  logic       last_of_run;
  modport source (output valid, output char_code, output with_shift, output last_of_run,
                  input ready);
  modport sink (input valid, input char_code, input with_shift, input last_of_run,
                output ready);
endinterface

interface mkd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/mkd_cfg_regs.sv]
`default_nettype none

module mkd_cfg_regs
  import mkd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mkd_cfg_if.sink   cfg,
  output cfg_t      regs
);

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DASH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAPS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RUSSIAN = 3'd6;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.operating_mode      <= MODE_DECODE;
      regs.dot_ticks           <= 12'd100;
      regs.dash_multiple       <= 4'd3;
      regs.letter_gap_multiple <= 4'd3;
      regs.word_gap_multiple   <= 4'd7;
      regs.caps_on             <= 1'b0;
      regs.russian_layout      <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MODE:    regs.operating_mode      <= cfg.data[1:0];
        REG_DOT:     regs.dot_ticks           <= cfg.data[11:0];
        REG_DASH:    regs.dash_multiple       <= cfg.data[3:0];
        REG_LETTER:  regs.letter_gap_multiple <= cfg.data[3:0];
        REG_WORD:    regs.word_gap_multiple   <= cfg.data[3:0];
        REG_CAPS:    regs.caps_on             <= cfg.data[0];
        REG_RUSSIAN: regs.russian_layout      <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mkd_core.sv]
`default_nettype none

`include "assert_macros.svh"

module mkd_core
  import mkd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 6,
  parameter int COUNT_BITS   = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  key_down,
  input  wire cfg_t                  cfg,
  output res_t [MAX_RUN-1:0]         res,
  output logic [RUN_W-1:0]           push_n
);

  localparam int LEN_W = $clog2(MAX_ELEMENTS + 2);

  logic [COUNT_BITS-1:0]   held;
  logic [COUNT_BITS-1:0]   held_next;
  logic [COUNT_BITS-1:0]   since;
  logic [COUNT_BITS-1:0]   since_next;
  logic                    prev_down;
  logic [MAX_ELEMENTS-1:0] code_bits;
  logic [MAX_ELEMENTS-1:0] code_bits_next;
  logic [LEN_W-1:0]        code_len;
  logic [LEN_W-1:0]        code_len_next;

  logic [COUNT_BITS-1:0] held_inc;
  logic [COUNT_BITS-1:0] since_inc;
  logic [TH_W-1:0]       dash_th;
  logic [TH_W-1:0]       letter_th;
  logic [TH_W-1:0]       word_th;
  logic                  active;
  logic                  dec;
  logic                  is_dash;
  logic                  is_elem;
  logic                  gap_letter;
  logic                  gap_word;
  logic [7:0]            lut_key;
  logic                  lut_ok;
  logic [6:0]            lat_ch;
  logic [6:0]            rus_ch;
  logic [6:0]            letter_ch;
  logic                  letter_shift;
  logic                  letter_hit;

  assign held_inc  = (held == '1) ? held : held + 1'b1;
  assign since_inc = (since == '1) ? since : since + 1'b1;

  assign dash_th   = TH_W'(cfg.dot_ticks) * TH_W'(cfg.dash_multiple);
  assign letter_th = TH_W'(cfg.dot_ticks) * TH_W'(cfg.letter_gap_multiple);
  assign word_th   = TH_W'(cfg.dot_ticks) * TH_W'(cfg.word_gap_multiple);

  assign active = (cfg.operating_mode == MODE_ECHO) || (cfg.operating_mode == MODE_DECODE);
  assign dec    = (cfg.operating_mode == MODE_DECODE);

  assign is_dash    = held_inc >= COUNT_BITS'(dash_th);
  assign is_elem    = is_dash || (held_inc >= COUNT_BITS'(cfg.dot_ticks));
  assign gap_letter = since_inc >= COUNT_BITS'(letter_th);
  assign gap_word   = since_inc >= COUNT_BITS'(word_th);

  assign lut_key = {code_len[2:0], code_bits[4:0]};
  assign lut_ok  = (code_len != '0) && (code_len <= LEN_W'(MAX_PATTERN));
  assign lat_ch  = latin_lookup(lut_key);
  assign rus_ch  = russian_lookup(lut_key);

  always_comb begin
    if (cfg.russian_layout) begin
      letter_ch    = rus_ch;
      letter_shift = cfg.caps_on && !((rus_ch >= CH_ZERO) && (rus_ch <= CH_NINE));
    end else begin
      letter_shift = 1'b0;
      if (cfg.caps_on && (lat_ch >= CH_LOWER_A) && (lat_ch <= CH_LOWER_Z)) begin
        letter_ch = lat_ch - CASE_DIFF;
      end else begin
        letter_ch = lat_ch;
      end
    end
  end

  assign letter_hit = lut_ok && (letter_ch != CH_NONE);

  always_comb begin
    res            = '0;
    push_n         = '0;
    held_next      = held_inc;
    since_next     = since_inc;
    code_bits_next = code_bits;
    code_len_next  = code_len;
    if (accept && active) begin
      if (!key_down) begin
        held_next = '0;
        if (prev_down) begin
          if (is_elem && !dec) begin
            res[0] = mk_res(is_dash ? CH_DASH : (cfg.russian_layout ? CH_SLASH : CH_DOT),
                            1'b0);
            push_n = 2'd1;
          end else if (is_elem) begin
            if (code_len < LEN_W'(MAX_ELEMENTS)) begin
              code_bits_next = {code_bits[MAX_ELEMENTS-2:0], is_dash};
              code_len_next  = code_len + 1'b1;
            end else begin
              code_len_next = LEN_W'(MAX_ELEMENTS + 1);
            end
          end
        end else if (dec && (code_len != '0) && gap_letter) begin
          if (letter_hit) begin
            res[0] = mk_res(letter_ch, letter_shift);
            push_n = 2'd1;
          end
          code_bits_next = '0;
          code_len_next  = '0;
        end
      end else if (!prev_down) begin
        since_next = '0;
        if (gap_word && dec) begin
          res[0] = mk_res(CH_SPACE, 1'b0);
          push_n = 2'd1;
        end else if (gap_word) begin
          res[0] = mk_res(CH_SPACE, 1'b0);
          res[1] = mk_res(cfg.russian_layout ? CH_BAR : CH_SLASH, 1'b0);
          res[2] = mk_res(CH_SPACE, 1'b0);
          push_n = 2'd3;
        end else if (!dec && gap_letter) begin
          res[0] = mk_res(CH_SPACE, 1'b0);
          push_n = 2'd1;
        end
      end
    end
    if (push_n != '0) begin
      res[push_n - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      since     <= '1;
      prev_down <= 1'b0;
      code_bits <= '0;
      code_len  <= '0;
    end else if (accept) begin
      held      <= held_next;
      since     <= since_next;
      prev_down <= key_down;
      code_bits <= code_bits_next;
      code_len  <= code_len_next;
    end
  end

  `MKD_NEVER(a_len_range, code_len > LEN_W'(MAX_ELEMENTS + 1), "code length out of range")
  `MKD_ASSERT(a_pass_quiet, accept && !active |-> push_n == '0, "output in passthrough")
  `MKD_ASSERT(a_held_clear, accept && active && !key_down |=> held == '0, "held not cleared")

endmodule

`default_nettype wire

[hw/rtl/mkd_out_fifo.sv]
`default_nettype none

`include "assert_macros.svh"

module mkd_out_fifo
  import mkd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire res_t [MAX_RUN-1:0] res,
  input  wire logic [RUN_W-1:0]   push_n,
  output logic                    space_ok,
  mkd_char_if.source              chars
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop      = chars.valid && chars.ready;
  assign space_ok = count <= CNT_W'(FIFO_DEPTH - MAX_RUN);

  assign chars.valid       = count != '0;
  assign chars.char_code   = mem[rd_ptr].char_code;
  assign chars.with_shift  = mem[rd_ptr].with_shift;
  assign chars.last_of_run = mem[rd_ptr].last_of_run;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RUN; i++) begin
      if (RUN_W'(i) < push_n) begin
        mem[wr_ptr + PTR_W'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  `MKD_NEVER(a_no_overflow, count > CNT_W'(FIFO_DEPTH), "output queue overflow")
  `MKD_ASSERT(a_fill, push_n != '0 && !pop |=> count == $past(count + CNT_W'(push_n)), "count slip")

endmodule

`default_nettype wire

[hw/rtl/morse_key_timing_decoder.sv]
// An accepted key sample writes its characters into the output queue, behind any characters already waiting there.
// Throughput: one sample per cycle while the 8-entry character queue has 3 free slots;
// a tick yields 0 to 3 characters, drained one transfer per cycle while chars.ready is high.
// Reset (rst, synchronous, active high): counters cleared, gap counter saturated,
// code emptied, queue emptied, registers back to their defaults.
`default_nettype none

module morse_key_timing_decoder
  import mkd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 6,
  parameter int COUNT_BITS   = 20
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mkd_cfg_if.sink    cfg,
  mkd_key_if.sink    keys,
  mkd_char_if.source chars
);

  cfg_t               regs;
  res_t [MAX_RUN-1:0] res;
  logic [RUN_W-1:0]   push_n;
  logic               space_ok;
  logic               accept;

  assign keys.ready = space_ok;
  assign accept     = keys.valid && keys.ready;

  mkd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mkd_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .key_down (keys.key_down),
    .cfg      (regs),
    .res      (res),
    .push_n   (push_n)
  );

  mkd_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .push_n   (push_n),
    .space_ok (space_ok),
    .chars    (chars)
  );

endmodule

`default_nettype wire
